// ===== design/broadcast_page_slot_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// broadcast page slot scheduler assertion macros
// immediate-implication and next-cycle checks, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BROADCAST_PAGE_SLOT_SCHEDULER_MACROS_SVH
`define BROADCAST_PAGE_SLOT_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define BPSS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpss check failed");
`define BPSS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpss check failed");
`else
`define BPSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BPSS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/bpss_pkg.sv =====
// ----------------------------------------------------------------------------
// bpss_pkg
// types, page numbers and codes shared by the slot scheduler modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpss_pkg;

  localparam int unsigned COMMON_GROUP_PERIOD_DEF = 13;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned SLOT_W  = 3;

  localparam logic [SLOT_W-1:0] SLOTS_PER_GROUP = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_SWAP       = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_SETTINGS   = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_TREADMILL  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_GENERAL_LAST = 3'd1;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ANSWERED = 2'd1;
  localparam logic [1:0] CMD_REQUEST  = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_C80  = 2'd2;
  localparam logic [1:0] KIND_C81  = 2'd3;

  localparam logic [7:0] PG_GENERAL   = 8'd16;
  localparam logic [7:0] PG_SETTINGS  = 8'd17;
  localparam logic [7:0] PG_METABOLIC = 8'd18;
  localparam logic [7:0] PG_TREADMILL = 8'd19;
  localparam logic [7:0] PG_CAPS      = 8'd54;
  localparam logic [7:0] PG_STATUS    = 8'd71;
  localparam logic [7:0] PG_COMMON80  = 8'd80;
  localparam logic [7:0] PG_COMMON81  = 8'd81;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] req_page;
    logic [7:0] req_count;
  } bpss_item_t;

  typedef struct packed {
    logic [7:0] sent_page;
    logic [1:0] slot_kind;
    logic       request_status;
  } bpss_result_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic [PHASE_W-1:0] group_phase;
    logic               status_due;
    logic [7:0]         request_remaining;
    logic [7:0]         request_page_held;
    logic               metabolic_next;
  } bpss_state_t;

endpackage

// ===== design/bpss_slot_logic.sv =====
// ----------------------------------------------------------------------------
// bpss_slot_logic
// slot choice and scheduler state update for one word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpss_slot_logic #(
  parameter int unsigned COMMON_GROUP_PERIOD = bpss_pkg::COMMON_GROUP_PERIOD_DEF
) (
  input  bpss_pkg::bpss_item_t   item,
  input  bpss_pkg::bpss_state_t  st,
  input  logic                   metabolic_enable,
  output bpss_pkg::bpss_state_t  st_next,
  output bpss_pkg::bpss_result_t res
);
  import bpss_pkg::*;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(COMMON_GROUP_PERIOD - 1);
  localparam logic [PHASE_W-1:0] PERIOD     = PHASE_W'(COMMON_GROUP_PERIOD);

  logic               common;
  logic               supported;
  logic [SLOT_W-1:0]  slot_inc;
  logic [PHASE_W-1:0] phase_inc;

  assign common    = (st.group_phase == LAST_PHASE);
  assign slot_inc  = st.slot_index + SLOT_W'(1);
  assign phase_inc = st.group_phase + PHASE_W'(1);
  assign supported = (item.req_page == PG_CAPS) || (item.req_page == PG_STATUS) ||
                     (item.req_page == PG_COMMON80) || (item.req_page == PG_COMMON81);

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (item.command)
      CMD_TICK: begin
        res.slot_kind = KIND_DATA;
        if (common && st.slot_index == SLOT_SWAP) begin
          res.sent_page = PG_COMMON80;
          res.slot_kind = KIND_C80;
        end else if (common && st.slot_index >= SLOT_SETTINGS) begin
          res.sent_page = PG_COMMON81;
          res.slot_kind = KIND_C81;
        end else if (st.slot_index <= SLOT_GENERAL_LAST) begin
          res.sent_page = PG_GENERAL;
        end else if (st.slot_index == SLOT_TREADMILL) begin
          res.sent_page = PG_TREADMILL;
        end else if (st.slot_index == SLOT_SWAP) begin
          // status owed beats a held request
          if (st.status_due) begin
            st_next.status_due = 1'b0;
            res.sent_page      = PG_STATUS;
          end else if (st.request_remaining != 8'd0) begin
            st_next.request_remaining = st.request_remaining - 8'd1;
            res.sent_page             = st.request_page_held;
          end else begin
            res.sent_page = PG_TREADMILL;
          end
        end else if (metabolic_enable && st.metabolic_next) begin
          res.sent_page          = PG_METABOLIC;
          st_next.metabolic_next = 1'b0;
        end else begin
          res.sent_page          = PG_SETTINGS;
          st_next.metabolic_next = metabolic_enable;
        end
        // slot and group counters, out-of-range values wrap to zero
        if (slot_inc >= SLOTS_PER_GROUP) begin
          st_next.slot_index  = '0;
          st_next.group_phase = (phase_inc >= PERIOD) ? '0 : phase_inc;
        end else begin
          st_next.slot_index = slot_inc;
        end
      end
      CMD_ANSWERED: begin
        st_next.status_due = 1'b1;
      end
      CMD_REQUEST: begin
        if (supported) begin
          st_next.request_page_held = item.req_page;
          st_next.request_remaining = (item.req_count == 8'd0) ? 8'd1 : item.req_count;
        end else begin
          res.request_status = 1'b1;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

// ===== design/broadcast_page_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// broadcast_page_slot_scheduler
// picks the broadcast page for each message slot of a five-slot group
// ----------------------------------------------------------------------------
// input words carry a command (tick, command answered, page request) with
// req_page and req_count; each is taken when in_valid is high and in_stall
// is low. every input word gives exactly one output word (sent_page,
// slot_kind, request_status), offered on out_valid and taken when out_stall
// is low. metabolic_enable is written through cfg_write / cfg_data; the
// user must write it only while the block is idle, as the block does not
// enforce this. a word is registered in the entry register, then its
// result in the output register, where out_valid marks it for taking.
// one word per clock is sustained while out_stall is low; the slot choice
// and state update sit in one short stage between the two registers.
// reset clears the slot and group counters, any owed status page, any held
// request and the metabolic setting. while out_stall holds a result, one
// further word is taken into the entry register, then in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "broadcast_page_slot_scheduler_macros.svh"

module broadcast_page_slot_scheduler #(
  parameter int unsigned COMMON_GROUP_PERIOD = bpss_pkg::COMMON_GROUP_PERIOD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] req_page,
  input  logic [7:0] req_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] sent_page,
  output logic [1:0] slot_kind,
  output logic       request_status
);
  import bpss_pkg::*;

  localparam logic [PHASE_W-1:0] PERIOD = PHASE_W'(COMMON_GROUP_PERIOD);

  logic         metabolic_enable;
  logic         in_reg_valid;
  bpss_item_t   in_reg;
  bpss_state_t  st;
  bpss_state_t  st_next;
  bpss_result_t res;
  bpss_result_t out_reg;
  logic         out_free;
  logic         advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_reg_valid && out_free;
  assign in_stall = in_reg_valid && !out_free;

  bpss_slot_logic #(
    .COMMON_GROUP_PERIOD(COMMON_GROUP_PERIOD)
  ) u_slot_logic (
    .item             (in_reg),
    .st               (st),
    .metabolic_enable (metabolic_enable),
    .st_next          (st_next),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      metabolic_enable <= 1'b0;
    end else if (cfg_write) begin
      metabolic_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
      st           <= '0;
    end else begin
      if (!in_stall) begin
        in_reg_valid <= in_valid;
      end
      if (advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg.command   <= command;
      in_reg.req_page  <= req_page;
      in_reg.req_count <= req_count;
    end
    if (advance) begin
      out_reg <= res;
    end
  end

  assign sent_page      = out_reg.sent_page;
  assign slot_kind      = out_reg.slot_kind;
  assign request_status = out_reg.request_status;

  `BPSS_ASSERT_IMP(a_slot_range, clk, rst, 1'b1, st.slot_index < SLOTS_PER_GROUP)
  `BPSS_ASSERT_IMP(a_phase_range, clk, rst, 1'b1, st.group_phase < PERIOD)
  `BPSS_ASSERT_IMP(a_stall_full, clk, rst, in_stall, in_reg_valid && out_valid)
  `BPSS_ASSERT_IMP(a_none_zero, clk, rst, out_valid && slot_kind == KIND_NONE, sent_page == 8'd0)
  `BPSS_ASSERT_NXT(a_state_hold, clk, rst, !advance, st == $past(st))

endmodule
